// ===== rtl/bit_slice_alu_with_register_file_core_assert.svh =====
// Assertion macros for the bit-slice ALU core.
`ifndef BIT_SLICE_ALU_WITH_REGISTER_FILE_CORE_ASSERT_SVH
`define BIT_SLICE_ALU_WITH_REGISTER_FILE_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define BSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsa assertion failed");
// Next-cycle implication checked outside reset.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsa assertion failed");
`endif

// ===== rtl/bsa_pkg.sv =====
// Shared constants, types and functions for the bit-slice ALU core.
package bsa_pkg;
   localparam int SLICES_DEF = 4;
   localparam int DATA_BITS = 16;
   localparam int REG_DEPTH = 16;
   localparam int ADDR_BITS = 4;

   // ALU operation codes.
   localparam logic [3:0] OP_HIGH = 4'd0;
   localparam logic [3:0] OP_SMR = 4'd1;
   localparam logic [3:0] OP_RMS = 4'd2;
   localparam logic [3:0] OP_ADD = 4'd3;
   localparam logic [3:0] OP_PS = 4'd4;
   localparam logic [3:0] OP_NS = 4'd5;
   localparam logic [3:0] OP_PR = 4'd6;
   localparam logic [3:0] OP_NR = 4'd7;
   localparam logic [3:0] OP_LOW = 4'd8;
   localparam logic [3:0] OP_NRAS = 4'd9;
   localparam logic [3:0] OP_XNOR = 4'd10;
   localparam logic [3:0] OP_XOR = 4'd11;
   localparam logic [3:0] OP_AND = 4'd12;
   localparam logic [3:0] OP_NOR = 4'd13;
   localparam logic [3:0] OP_NAND = 4'd14;

   // Special step codes.
   localparam logic [3:0] SP_UMUL = 4'd0;
   localparam logic [3:0] SP_TMUL = 4'd2;
   localparam logic [3:0] SP_INC = 4'd4;
   localparam logic [3:0] SP_SGNM = 4'd5;
   localparam logic [3:0] SP_TMULL = 4'd6;
   localparam logic [3:0] SP_NORM = 4'd8;
   localparam logic [3:0] SP_DNORM = 4'd10;
   localparam logic [3:0] SP_DIV = 4'd12;
   localparam logic [3:0] SP_DIVC = 4'd14;

   // Destination codes.
   localparam logic [3:0] DST_SIGN = 4'd14;

   // Word width as set by the slice count.
   function automatic int word_bits(input int slices);
      int w;
      w = 4 * slices;
      if (w < 4) w = 4;
      if (w > DATA_BITS) w = DATA_BITS;
      return w;
   endfunction

   // Registered input beat.
   typedef struct packed {
      logic [ADDR_BITS-1:0] a_addr;
      logic [ADDR_BITS-1:0] b_addr;
      logic [DATA_BITS-1:0] a_ext;
      logic [DATA_BITS-1:0] b_ext;
      logic [8:0] func;
      logic carry_in;
      logic [1:0] src_sel;
      logic write_disable;
      logic [1:0] f_shift_in;
      logic [1:0] q_shift_in;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [DATA_BITS-1:0] y;
      logic c4;
      logic v;
      logic neg;
      logic z;
      logic [1:0] fso;
      logic [1:0] qso;
   } rsp_type;

   // State write-back request.
   typedef struct packed {
      logic wr_reg;
      logic wr_q;
      logic [ADDR_BITS-1:0] addr;
      logic [DATA_BITS-1:0] y;
      logic [DATA_BITS-1:0] q;
   } wb_type;
endpackage

// ===== rtl/bsa_exec.sv =====
// Combinational ALU, shifter and special-step logic for one beat.
module bsa_exec import bsa_pkg::*; #(
   parameter int SLICES = SLICES_DEF
) (
   input  req_type               req,
   input  logic [DATA_BITS-1:0]  ra,
   input  logic [DATA_BITS-1:0]  rb,
   input  logic [DATA_BITS-1:0]  q_cur,
   output rsp_type               rsp,
   output wb_type                wb
);
   localparam int W = word_bits(SLICES);
   typedef logic [W-1:0] w_type;
   typedef logic [W:0] e_type;
   localparam w_type M = '1;

   // W+1 bit add with separate carry for the flag.
   function automatic void add(input e_type r, input e_type s, input logic cf,
                               input logic cc, output w_type f, output logic c,
                               output logic v);
      e_type sum;
      logic [W:0] cs;
      sum = r + s + e_type'(cf);
      cs = {1'b0, r[W-1:0]} + {1'b0, s[W-1:0]} + (W+1)'(cc);
      v = sum[W] ^ sum[W-1];
      c = cs[W];
      f = sum[W-1:0];
   endfunction

   function automatic w_type sra(input w_type x, input logic i);
      w_type o;
      o = x >> 1;
      o[W-1] = x[W-1];
      o[W-2] = i;
      return o;
   endfunction
   function automatic w_type srl(input w_type x, input logic i);
      return {i, x[W-1:1]};
   endfunction
   function automatic w_type sll(input w_type x, input logic i);
      return {x[W-2:0], i};
   endfunction
   function automatic w_type sla(input w_type x, input logic i);
      return {x[W-1], x[W-3:0], i};
   endfunction

   always_comb begin
      w_type r, s, q, f, y, nq, ts;
      e_type er, es, t;
      logic c4, v, neg, z, wr_reg, wr_q, tb;
      logic pf3, pf0, pq3, pq0;
      logic [3:0] ko, op;
      logic i0, c0;
      ko = req.func[8:5];
      op = req.func[4:1];
      i0 = req.func[0];
      c0 = req.carry_in;
      q = q_cur[W-1:0];
      r = req.src_sel[1] ? req.a_ext[W-1:0] : ra[W-1:0];
      s = i0 ? q : (req.src_sel[0] ? req.b_ext[W-1:0] : rb[W-1:0]);
      er = {r[W-1], r};
      es = {s[W-1], s};
      pf3 = req.f_shift_in[1];
      pf0 = req.f_shift_in[0];
      pq3 = req.q_shift_in[1];
      pq0 = req.q_shift_in[0];
      f = '0; y = '0; nq = q; c4 = 1'b0; v = 1'b0; neg = 1'b0; z = 1'b0;
      wr_reg = 1'b1; wr_q = 1'b1; t = '0; tb = 1'b0; ts = '0;
      if (op != 4'd0 || i0) begin
         // Normal ALU function.
         case (op)
            OP_HIGH: f = M;
            OP_SMR: add(~er, es, c0, c0, f, c4, v);
            OP_RMS: add(er, ~es, c0, c0, f, c4, v);
            OP_ADD: add(er, es, c0, c0, f, c4, v);
            OP_PS: add('0, es, c0, c0, f, c4, v);
            OP_NS: add('0, ~es, c0, c0, f, c4, v);
            OP_PR: add(er, '0, c0, c0, f, c4, v);
            OP_NR: add(~er, '0, c0, c0, f, c4, v);
            OP_LOW: f = '0;
            OP_NRAS: f = ~r & s;
            OP_XNOR: f = ~(r ^ s);
            OP_XOR: f = r ^ s;
            OP_AND: f = r & s;
            OP_NOR: f = ~(r | s);
            OP_NAND: f = ~(r & s);
            default: f = r | s;
         endcase
         neg = f[W-1];
         // Destination control.
         case (ko)
            4'd0: begin y = sra(f, pf3); pf0 = f[0]; end
            4'd1: begin y = srl(f, pf3); pf0 = f[0]; end
            4'd2: begin
               y = sra(f, pf3); pf0 = f[0]; nq = srl(q, pq3); pq0 = q[0];
            end
            4'd3: begin
               y = srl(f, pf3); pf0 = f[0]; nq = srl(q, pq3); pq0 = q[0];
            end
            4'd4: y = f;
            4'd5: begin y = f; nq = srl(q, pq3); pq0 = q[0]; wr_reg = 1'b0; end
            4'd6: begin y = f; nq = f; end
            4'd7: begin y = f; nq = f; wr_reg = 1'b0; end
            4'd8: begin y = sla(f, pf0); pf3 = f[W-2]; end
            4'd9: begin y = sll(f, pf0); pf3 = f[W-1]; end
            4'd10: begin
               nq = sll(q, pq0); pq3 = q[W-1]; y = sla(f, pf0); pf3 = f[W-2];
            end
            4'd11: begin
               nq = sll(q, pq0); pq3 = q[W-1]; y = sll(f, pf0); pf3 = f[W-1];
            end
            4'd12: begin y = f; wr_reg = 1'b0; end
            4'd13: begin y = f; nq = sll(q, pq0); pq3 = q[W-1]; wr_reg = 1'b0; end
            DST_SIGN: y = pf0 ? M : '0;
            default: y = f;
         endcase
         z = (y == '0);
      end else begin
         // Special steps.
         case (ko)
            SP_UMUL, SP_TMUL, SP_TMULL: begin
               z = q[0];
               if (ko == SP_TMULL) t = z ? ~er : '0;
               else t = z ? er : '0;
               add(t, es, c0, c0, f, c4, v);
               neg = f[W-1];
               if (ko == SP_UMUL) tb = c4;
               else begin pf3 = neg ^ v; tb = pf3; end
               y = srl(f, tb);
               pf0 = f[0];
               pq0 = q[0];
               nq = srl(q, pf0);
            end
            SP_INC: begin
               add(e_type'(1), es, c0, c0, f, c4, v);
               neg = f[W-1];
               z = (f == '0);
               y = f;
            end
            SP_SGNM: begin
               z = s[W-1];
               add('0, z ? ~es : es, z, c0, f, c4, v);
               if (z) f[W-1] = 1'b1;
               v = 1'b0;
               neg = z;
               y = f;
            end
            SP_NORM: begin
               c4 = q[W-1] ^ q[W-2];
               v = q[W-2] ^ q[W-3];
               z = (q == '0);
               ts = s + w_type'(c0);
               f = ts;
               neg = f[W-1];
               y = f;
               if (!z && !c4) nq = {q[W-2:0], 1'b0};
            end
            SP_DNORM: begin
               z = ((q | s) == '0);
               add('0, es, c0, c0, f, c4, v);
               neg = f[W-1];
               if (!z && !c4) begin
                  pq3 = q[W-1];
                  nq = {q[W-2:0], 1'b0};
                  pf3 = f[W-1];
                  y = sll(f, pq3);
               end else begin
                  y = f;
               end
            end
            SP_DIV, SP_DIVC: begin
               z = ~r[W-1];
               add(z ? ~er : er, es, z, c0, f, c4, v);
               neg = f[W-1];
               pf0 = q[W-1];
               if (ko == SP_DIV) begin
                  nq = sll(q, ~(f[W-1] ^ r[W-1]));
                  pf3 = f[W-1];
                  y = sll(f, pf0);
               end else begin
                  pq0 = 1'b1;
                  nq = sll(q, 1'b1);
                  y = f;
               end
            end
            default: begin
               wr_reg = 1'b0;
               wr_q = 1'b0;
            end
         endcase
      end
      rsp.y = DATA_BITS'(y);
      rsp.c4 = c4;
      rsp.v = v;
      rsp.neg = neg;
      rsp.z = z;
      rsp.fso = {pf3, pf0};
      rsp.qso = {pq3, pq0};
      wb.wr_reg = wr_reg & ~req.write_disable;
      wb.wr_q = wr_q & ~req.write_disable;
      wb.addr = req.b_addr;
      wb.y = DATA_BITS'(y);
      wb.q = DATA_BITS'(nq);
   end
endmodule

// ===== rtl/bsa_state.sv =====
// Register file and Q register with write-back port.
module bsa_state import bsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wb_en,
   input  wb_type                wb,
   input  logic [ADDR_BITS-1:0]  a_addr,
   input  logic [ADDR_BITS-1:0]  b_addr,
   output logic [DATA_BITS-1:0]  ra,
   output logic [DATA_BITS-1:0]  rb,
   output logic [DATA_BITS-1:0]  q
);
   logic [DATA_BITS-1:0] rf_ff [REG_DEPTH];
   logic [DATA_BITS-1:0] q_ff;

   // Sixteen words in flops, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_DEPTH; i++) rf_ff[i] <= '0;
         q_ff <= '0;
      end else if (wb_en) begin
         if (wb.wr_reg) rf_ff[wb.addr] <= wb.y;
         if (wb.wr_q) q_ff <= wb.q;
      end
   end

   assign ra = rf_ff[a_addr];
   assign rb = rf_ff[b_addr];
   assign q = q_ff;
endmodule

// ===== rtl/bit_slice_alu_with_register_file_core.sv =====
// Top level of the bit-slice ALU core with register file and Q register.
//  channel  dir  handshake          payload
//  req      in   req_valid/ready    addresses, external data, func, pins
//  rsp      out  rsp_valid/ready    y_out, flags, shift-out pins
// An accepted beat is registered, then evaluated and written back when it
// advances, with its result loaded into the output register: one beat
// per cycle while the output register is not stalled.
// The evaluation cycle reads the register file and Q as the previous beat
// left them, so back-to-back beats see each other's writes.
// A beat moves from the input register only when the output register is
// free or being drained; reset empties both stages and clears the state.
`include "bit_slice_alu_with_register_file_core_assert.svh"
module bit_slice_alu_with_register_file_core import bsa_pkg::*; #(
   parameter int SLICES = SLICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADDR_BITS-1:0]  req_a_addr,
   input  logic [ADDR_BITS-1:0]  req_b_addr,
   input  logic [DATA_BITS-1:0]  req_a_ext,
   input  logic [DATA_BITS-1:0]  req_b_ext,
   input  logic [8:0]            req_func,
   input  logic                  req_carry_in,
   input  logic [1:0]            req_src_sel,
   input  logic                  req_write_disable,
   input  logic [1:0]            req_f_shift_in,
   input  logic [1:0]            req_q_shift_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_BITS-1:0]  rsp_y_out,
   output logic                  rsp_carry_out,
   output logic                  rsp_overflow,
   output logic                  rsp_negative,
   output logic                  rsp_zero,
   output logic [1:0]            rsp_f_shift_out,
   output logic [1:0]            rsp_q_shift_out
);
   req_type req_ff;
   logic    req_vld_ff, req_vld_in;
   rsp_type rsp_ff;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_calc;
   wb_type  wb;
   logic [DATA_BITS-1:0] ra, rb, q;
   logic    advance;

   // The stage advances when the output register is empty or draining.
   assign advance = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign req_vld_in = (req_valid && req_ready) || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) req_vld_ff <= 1'b0;
      else req_vld_ff <= req_vld_in;
   end
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= '{a_addr: req_a_addr, b_addr: req_b_addr, a_ext: req_a_ext,
                     b_ext: req_b_ext, func: req_func, carry_in: req_carry_in,
                     src_sel: req_src_sel, write_disable: req_write_disable,
                     f_shift_in: req_f_shift_in, q_shift_in: req_q_shift_in};
      end
   end

   bsa_state u_state (
      .clock(clock), .reset(reset), .wb_en(advance), .wb(wb),
      .a_addr(req_ff.a_addr), .b_addr(req_ff.b_addr), .ra(ra), .rb(rb), .q(q)
   );

   bsa_exec #(.SLICES(SLICES)) u_exec (
      .req(req_ff), .ra(ra), .rb(rb), .q_cur(q), .rsp(rsp_calc), .wb(wb)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else rsp_vld_ff <= rsp_vld_in;
   end
   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_calc;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_y_out = rsp_ff.y;
   assign rsp_carry_out = rsp_ff.c4;
   assign rsp_overflow = rsp_ff.v;
   assign rsp_negative = rsp_ff.neg;
   assign rsp_zero = rsp_ff.z;
   assign rsp_f_shift_out = rsp_ff.fso;
   assign rsp_q_shift_out = rsp_ff.qso;

   // A beat that advances always lands a result in the next cycle.
   `BSA_ASSERT_NEXT(a_adv_rsp, clock, reset, advance, rsp_vld_ff)
   // A stalled result keeps the input stage from advancing.
   `BSA_ASSERT_IMP(a_stall_hold, clock, reset, rsp_vld_ff && !rsp_ready, !advance)
   // A waiting beat that cannot advance holds its stage.
   `BSA_ASSERT_NEXT(a_req_hold, clock, reset, req_vld_ff && !advance, req_vld_ff)
endmodule

// ===== dv/bit_slice_alu_with_register_file_core_checker.sv =====
// Checker for the bit-slice ALU core: predicts each result beat and compares it.
module bit_slice_alu_with_register_file_core_checker import bsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [ADDR_BITS-1:0] req_a_addr,
   input  logic [ADDR_BITS-1:0] req_b_addr,
   input  logic [DATA_BITS-1:0] req_a_ext,
   input  logic [DATA_BITS-1:0] req_b_ext,
   input  logic [8:0]           req_func,
   input  logic                 req_carry_in,
   input  logic [1:0]           req_src_sel,
   input  logic                 req_write_disable,
   input  logic [1:0]           req_f_shift_in,
   input  logic [1:0]           req_q_shift_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [DATA_BITS-1:0] rsp_y_out,
   input  logic                 rsp_carry_out,
   input  logic                 rsp_overflow,
   input  logic                 rsp_negative,
   input  logic                 rsp_zero,
   input  logic [1:0]           rsp_f_shift_out,
   input  logic [1:0]           rsp_q_shift_out,
   output int                   errors,
   output int                   pending
);
   localparam int W = (4 * SLICES_DEF > DATA_BITS) ? DATA_BITS :
                      ((4 * SLICES_DEF < 4) ? 4 : 4 * SLICES_DEF);
   localparam bit [31:0] MASK = (32'd1 << W) - 32'd1;

   // Shadow copy of the register file and Q.
   bit [31:0] regs [REG_DEPTH];
   bit [31:0] q_shadow;
   rsp_type   expected_rsps [$];

   function automatic bit [31:0] msb(bit [31:0] x);
      return (x >> (W - 1)) & 32'd1;
   endfunction

   function automatic bit [31:0] sx(bit [31:0] x);
      return x | (msb(x) << W);
   endfunction

   function automatic bit [31:0] nx(bit [31:0] x);
      return ~x & ((32'd1 << (W + 1)) - 32'd1);
   endfunction

   function automatic void adder(input bit [31:0] r, s, cf, cc,
                                 output bit [31:0] f, c4, v);
      bit [31:0] sum;
      sum = r + s + cf;
      v = ((sum >> W) ^ (sum >> (W - 1))) & 32'd1;
      c4 = (((r & MASK) + (s & MASK) + cc) >> W) & 32'd1;
      f = sum & MASK;
   endfunction

   function automatic bit [31:0] srl1(bit [31:0] x, bit [31:0] i);
      return ((x >> 1) | (i << (W - 1))) & MASK;
   endfunction

   function automatic bit [31:0] sra1(bit [31:0] x, bit [31:0] i);
      return (x & (32'd1 << (W - 1))) | (i << (W - 2)) |
             ((x >> 1) & ((32'd1 << (W - 2)) - 32'd1));
   endfunction

   function automatic bit [31:0] sll1(bit [31:0] x, bit [31:0] i);
      return ((x << 1) | i) & MASK;
   endfunction

   function automatic bit [31:0] sla1(bit [31:0] x, bit [31:0] i);
      return (x & (32'd1 << (W - 1))) | (((x << 1) | i) & (MASK >> 1));
   endfunction

   // Executes one microinstruction on the shadow state and returns its result.
   function automatic rsp_type execute(req_type x);
      bit [31:0] r, s, q, f, y, nq, c4, v, neg, z, t, er, es, c0;
      bit [31:0] pf3, pf0, pq3, pq0;
      bit [3:0]  ko, op;
      bit        i0, wr_reg, wr_q;
      rsp_type   o;
      ko = x.func[8:5]; op = x.func[4:1]; i0 = x.func[0];
      c0 = 32'(x.carry_in);
      pf3 = 32'(x.f_shift_in[1]); pf0 = 32'(x.f_shift_in[0]);
      pq3 = 32'(x.q_shift_in[1]); pq0 = 32'(x.q_shift_in[0]);
      q = q_shadow & MASK;
      r = (x.src_sel[1] ? 32'(x.a_ext) : regs[x.a_addr]) & MASK;
      s = (i0 ? q : (x.src_sel[0] ? 32'(x.b_ext) : regs[x.b_addr])) & MASK;
      f = 0; y = 0; nq = q; c4 = 0; v = 0; neg = 0; z = 0;
      wr_reg = 1'b1; wr_q = 1'b1;
      er = sx(r); es = sx(s);
      if (op != 0 || i0) begin
         case (op)
            OP_HIGH: f = MASK;
            OP_SMR:  adder(nx(er), es, c0, c0, f, c4, v);
            OP_RMS:  adder(er, nx(es), c0, c0, f, c4, v);
            OP_ADD:  adder(er, es, c0, c0, f, c4, v);
            OP_PS:   adder(0, es, c0, c0, f, c4, v);
            OP_NS:   adder(0, nx(es), c0, c0, f, c4, v);
            OP_PR:   adder(er, 0, c0, c0, f, c4, v);
            OP_NR:   adder(nx(er), 0, c0, c0, f, c4, v);
            OP_LOW:  f = 0;
            OP_NRAS: f = ~r & s;
            OP_XNOR: f = ~(r ^ s);
            OP_XOR:  f = r ^ s;
            OP_AND:  f = r & s;
            OP_NOR:  f = ~(r | s);
            OP_NAND: f = ~(r & s);
            default: f = r | s;
         endcase
         f &= MASK;
         neg = msb(f);
         // Destination decode: shifts of F and Q and the write enables.
         case (ko)
            4'd0: begin y = sra1(f, pf3); pf0 = f & 1; end
            4'd1: begin y = srl1(f, pf3); pf0 = f & 1; end
            4'd2: begin
               y = sra1(f, pf3); pf0 = f & 1; nq = srl1(q, pq3); pq0 = q & 1;
            end
            4'd3: begin
               y = srl1(f, pf3); pf0 = f & 1; nq = srl1(q, pq3); pq0 = q & 1;
            end
            4'd4: y = f;
            4'd5: begin y = f; nq = srl1(q, pq3); pq0 = q & 1; wr_reg = 1'b0; end
            4'd6: begin y = f; nq = f; end
            4'd7: begin y = f; nq = f; wr_reg = 1'b0; end
            4'd8: begin y = sla1(f, pf0); pf3 = (f >> (W - 2)) & 1; end
            4'd9: begin y = sll1(f, pf0); pf3 = msb(f); end
            4'd10: begin
               nq = sll1(q, pq0); pq3 = msb(q);
               y = sla1(f, pf0); pf3 = (f >> (W - 2)) & 1;
            end
            4'd11: begin
               nq = sll1(q, pq0); pq3 = msb(q); y = sll1(f, pf0); pf3 = msb(f);
            end
            4'd12: begin y = f; wr_reg = 1'b0; end
            4'd13: begin y = f; nq = sll1(q, pq0); pq3 = msb(q); wr_reg = 1'b0; end
            DST_SIGN: y = pf0 ? MASK : 0;
            default: y = f;
         endcase
         z = 32'(y == 0);
      end else begin
         // Special steps: multiply, increment, sign-magnitude, normalize, divide.
         case (ko)
            SP_UMUL, SP_TMUL, SP_TMULL: begin
               z = q & 1;
               if (ko == SP_TMULL) t = z ? nx(er) : 0;
               else t = z ? er : 0;
               adder(t, es, c0, c0, f, c4, v);
               neg = msb(f);
               if (ko == SP_UMUL) t = c4;
               else begin pf3 = neg ^ v; t = pf3; end
               y = srl1(f, t);
               pf0 = f & 1;
               pq0 = q & 1;
               nq = srl1(q, pf0);
            end
            SP_INC: begin
               adder(1, es, c0, c0, f, c4, v);
               neg = msb(f); z = 32'(f == 0); y = f;
            end
            SP_SGNM: begin
               z = msb(s);
               adder(0, z ? nx(es) : es, z, c0, f, c4, v);
               if (z) f |= 32'd1 << (W - 1);
               v = 0; neg = z; y = f;
            end
            SP_NORM: begin
               c4 = (msb(q) ^ (q >> (W - 2))) & 1;
               v = ((q >> (W - 2)) ^ (q >> (W - 3))) & 1;
               z = 32'(q == 0);
               f = (s + c0) & MASK;
               neg = msb(f); y = f;
               if (!z && !c4) nq = (q << 1) & MASK;
            end
            SP_DNORM: begin
               z = 32'((q | s) == 0);
               adder(0, es, c0, c0, f, c4, v);
               neg = msb(f);
               if (!z && !c4) begin
                  pq3 = msb(q); nq = (q << 1) & MASK; pf3 = msb(f); y = sll1(f, pq3);
               end else begin
                  y = f;
               end
            end
            SP_DIV, SP_DIVC: begin
               z = msb(r) ^ 1;
               adder(z ? nx(er) : er, es, z, c0, f, c4, v);
               neg = msb(f);
               pf0 = msb(q);
               if (ko == SP_DIV) begin
                  t = (msb(f) ^ msb(r)) ^ 1;
                  nq = sll1(q, t); pf3 = msb(f); y = sll1(f, pf0);
               end else begin
                  pq0 = 1; nq = sll1(q, 1); y = f;
               end
            end
            default: begin wr_reg = 1'b0; wr_q = 1'b0; end
         endcase
      end
      if (!x.write_disable) begin
         if (wr_q) q_shadow = nq & MASK;
         if (wr_reg) regs[x.b_addr] = y & MASK;
      end
      o.y = DATA_BITS'(y & MASK); o.c4 = c4[0]; o.v = v[0]; o.neg = neg[0]; o.z = z[0];
      o.fso = {pf3[0], pf0[0]}; o.qso = {pq3[0], pq0[0]};
      return o;
   endfunction

   assign pending = expected_rsps.size();

   // Predict on each accepted request beat and compare each accepted result beat.
   always @(posedge clock) begin
      req_type req;
      rsp_type want, got;
      if (reset) begin
         foreach (regs[i]) regs[i] = 0;
         q_shadow = 0;
         expected_rsps.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_y_out, rsp_carry_out, rsp_overflow, rsp_negative, rsp_zero,
                    rsp_f_shift_out, rsp_q_shift_out};
            if (expected_rsps.size() == 0) begin
               $display("%0t: result beat with none expected: %p", $time, got);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.y !== want.y) begin
                  $display("%0t: y_out expected %h actual %h", $time, want.y, got.y);
                  errors++;
               end
               if (got.c4 !== want.c4) begin
                  $display("%0t: carry_out expected %b actual %b", $time, want.c4, got.c4);
                  errors++;
               end
               if (got.v !== want.v) begin
                  $display("%0t: overflow expected %b actual %b", $time, want.v, got.v);
                  errors++;
               end
               if (got.neg !== want.neg) begin
                  $display("%0t: negative expected %b actual %b", $time, want.neg, got.neg);
                  errors++;
               end
               if (got.z !== want.z) begin
                  $display("%0t: zero expected %b actual %b", $time, want.z, got.z);
                  errors++;
               end
               if (got.fso !== want.fso) begin
                  $display("%0t: f_shift_out expected %b actual %b", $time, want.fso,
                           got.fso);
                  errors++;
               end
               if (got.qso !== want.qso) begin
                  $display("%0t: q_shift_out expected %b actual %b", $time, want.qso,
                           got.qso);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req = '{req_a_addr, req_b_addr, req_a_ext, req_b_ext, req_func, req_carry_in,
                    req_src_sel, req_write_disable, req_f_shift_in, req_q_shift_in};
            expected_rsps.push_back(execute(req));
         end
      end
   end
endmodule

// ===== dv/bit_slice_alu_with_register_file_core_tb.sv =====
// Top of the bit-slice ALU core testbench: clock, reset, stimulus and verdict.
module bit_slice_alu_with_register_file_core_tb;
   import bsa_pkg::*;

   localparam int RANDOM_BEATS = 1800;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic [ADDR_BITS-1:0] req_a_addr = '0;
   logic [ADDR_BITS-1:0] req_b_addr = '0;
   logic [DATA_BITS-1:0] req_a_ext = '0;
   logic [DATA_BITS-1:0] req_b_ext = '0;
   logic [8:0]           req_func = '0;
   logic                 req_carry_in = 0;
   logic [1:0]           req_src_sel = '0;
   logic                 req_write_disable = 0;
   logic [1:0]           req_f_shift_in = '0;
   logic [1:0]           req_q_shift_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic [DATA_BITS-1:0] rsp_y_out;
   logic                 rsp_carry_out, rsp_overflow, rsp_negative, rsp_zero;
   logic [1:0]           rsp_f_shift_out, rsp_q_shift_out;
   int                   errors, pending;
   bit                   stim_done = 0;

   bit_slice_alu_with_register_file_core dut (.*);
   bit_slice_alu_with_register_file_core_checker chk (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one request beat at the falling edge and holds it until accepted.
   task automatic send_beat(input logic [8:0] func, input logic [15:0] a_ext, b_ext,
                            input logic [1:0] src, input logic cin, input logic wd);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_func <= func;
      req_a_ext <= a_ext;
      req_b_ext <= b_ext;
      req_src_sel <= src;
      req_carry_in <= cin;
      req_write_disable <= wd;
      req_a_addr <= ADDR_BITS'($urandom_range(0, 15));
      req_b_addr <= ADDR_BITS'($urandom_range(0, 15));
      req_f_shift_in <= 2'($urandom_range(0, 3));
      req_q_shift_in <= 2'($urandom_range(0, 3));
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Result side stalls at random between ready phases, none of them empty.
   initial begin
      int g;
      @(negedge clock);
      while (!stim_done || pending != 0) begin
         rsp_ready <= 1;
         repeat (gap_len() + 1) @(negedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(negedge clock);
         end
      end
      rsp_ready <= 1;
   end

   initial begin
      logic [3:0] codes [10];
      logic [8:0] fn;
      codes = '{SP_UMUL, SP_TMUL, SP_INC, SP_SGNM, SP_TMULL, SP_NORM, SP_DNORM, SP_DIV,
                SP_DIVC, 4'd1};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: ops and destinations 1 to 15 with extreme operands, then each special step.
      for (int i = 0; i < 16; i++)
         send_beat({i[3:0], i[3:0], i[0]}, i[1] ? 16'hFFFF : 16'h0000,
                   i[2] ? 16'h8000 : 16'h7FFF, i[1:0], i[0], i == 15);
      foreach (codes[k])
         send_beat({codes[k], 5'b0}, 16'h8000, k[0] ? 16'hFFFF : 16'h0001,
                   k[1:0], k[0], 1'b0);
      // Random: mostly ordinary instructions, a share of special steps.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         fn = 9'($urandom_range(0, 511));
         if ($urandom_range(0, 3) == 0) fn[4:0] = 5'b0;
         send_beat(fn,
                   $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 7) == 0 ? 16'h8000 : 16'($urandom_range(0, 65535)),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7) == 0);
      end
      req_valid <= 0;
      stim_done = 1;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
